// File: rtl/iirbpd_pkg.sv
// Package for the bandpass envelope event detector: widths, coefficients, codes and the microprogram.
`default_nettype none
package iirbpd_pkg;

	localparam int SAMPLE_WIDTH_DEF = 19;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int COEF_W   = 32;
	localparam int ACC_FRAC = 30;
	localparam int HIST_W   = 40;
	localparam int OUT_W    = 21;
	localparam int THR_W    = 20;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1100);

	// Q2.30 coefficients, rounded to nearest from ten decimal places.
	localparam logic [63:0] Q30_NUM = 64'd536870912;
	localparam logic [63:0] Q30_RND = 64'd2500000000;
	localparam logic [63:0] Q30_DEN = 64'd5000000000;

	localparam logic signed [COEF_W-1:0] BP_B0 =
		$signed(COEF_W'((64'd3705549358 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] BP_B2 =
		-$signed(COEF_W'((64'd7411098715 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] BP_B4 = BP_B0;
	localparam logic signed [COEF_W-1:0] BP_A1 =
		-$signed(COEF_W'((64'd15634341687 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] BP_A2 =
		$signed(COEF_W'((64'd4548488847 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] BP_A3 =
		-$signed(COEF_W'((64'd723023604 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] BP_A4 =
		$signed(COEF_W'((64'd1870198984 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] ENV_B0 =
		$signed(COEF_W'((64'd36216815 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] ENV_B1 =
		$signed(COEF_W'((64'd72433630 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] ENV_B2 = ENV_B0;
	localparam logic signed [COEF_W-1:0] ENV_A1 =
		-$signed(COEF_W'((64'd18226949252 * Q30_NUM + Q30_RND) / Q30_DEN));
	localparam logic signed [COEF_W-1:0] ENV_A2 =
		$signed(COEF_W'((64'd8371816513 * Q30_NUM + Q30_RND) / Q30_DEN));

	// Event codes.
	localparam logic [1:0] EVT_NONE  = 2'd0;
	localparam logic [1:0] EVT_START = 2'd1;
	localparam logic [1:0] EVT_STOP  = 2'd2;

	// Register indexes.
	localparam logic REG_THRESHOLD = 1'b0;

	// Control word operations.
	localparam logic [1:0] OP_NOP     = 2'd0;
	localparam logic [1:0] OP_MAC     = 2'd1;
	localparam logic [1:0] OP_BP_END  = 2'd2;
	localparam logic [1:0] OP_ENV_END = 2'd3;

	// Multiplier operand sources.
	localparam logic [3:0] SRC_SAMPLE = 4'd0;
	localparam logic [3:0] SRC_BPX1   = 4'd1;
	localparam logic [3:0] SRC_BPX3   = 4'd2;
	localparam logic [3:0] SRC_BPY0   = 4'd3;
	localparam logic [3:0] SRC_BPY1   = 4'd4;
	localparam logic [3:0] SRC_BPY2   = 4'd5;
	localparam logic [3:0] SRC_BPY3   = 4'd6;
	localparam logic [3:0] SRC_RECT   = 4'd7;
	localparam logic [3:0] SRC_ENVX0  = 4'd8;
	localparam logic [3:0] SRC_ENVX1  = 4'd9;
	localparam logic [3:0] SRC_ENVY0  = 4'd10;
	localparam logic [3:0] SRC_ENVY1  = 4'd11;

	// Operand part: whole integer, low fraction bits or high bits of a history word.
	localparam logic [1:0] PART_INT = 2'd0;
	localparam logic [1:0] PART_LO  = 2'd1;
	localparam logic [1:0] PART_HI  = 2'd2;

	// Coefficient selects.
	localparam logic [3:0] C_BP_B0  = 4'd0;
	localparam logic [3:0] C_BP_B2  = 4'd1;
	localparam logic [3:0] C_BP_B4  = 4'd2;
	localparam logic [3:0] C_BP_A1  = 4'd3;
	localparam logic [3:0] C_BP_A2  = 4'd4;
	localparam logic [3:0] C_BP_A3  = 4'd5;
	localparam logic [3:0] C_BP_A4  = 4'd6;
	localparam logic [3:0] C_ENV_B0 = 4'd7;
	localparam logic [3:0] C_ENV_B1 = 4'd8;
	localparam logic [3:0] C_ENV_B2 = 4'd9;
	localparam logic [3:0] C_ENV_A1 = 4'd10;
	localparam logic [3:0] C_ENV_A2 = 4'd11;

	// Sequencing.
	localparam logic NXT_STEP     = 1'b0;
	localparam logic NXT_WAIT_OUT = 1'b1;

	localparam int NUM_STEPS = 22;
	localparam int STEP_W    = $clog2(NUM_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] src;
		logic [1:0] part;
		logic [3:0] coef;
		logic       sub;
		logic       first;
		logic       nxt;
	} ucode_t;

	function automatic logic signed [COEF_W-1:0] coef_rom(input logic [3:0] sel);
		logic signed [COEF_W-1:0] c;
		case (sel)
			C_BP_B0:  c = BP_B0;
			C_BP_B2:  c = BP_B2;
			C_BP_B4:  c = BP_B4;
			C_BP_A1:  c = BP_A1;
			C_BP_A2:  c = BP_A2;
			C_BP_A3:  c = BP_A3;
			C_BP_A4:  c = BP_A4;
			C_ENV_B0: c = ENV_B0;
			C_ENV_B1: c = ENV_B1;
			C_ENV_B2: c = ENV_B2;
			C_ENV_A1: c = ENV_A1;
			C_ENV_A2: c = ENV_A2;
			default:  c = '0;
		endcase
		return c;
	endfunction

	// The microprogram: bandpass section, then envelope section.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			STEP_W'(0):  w = '{OP_MAC, SRC_SAMPLE, PART_INT, C_BP_B0, 1'b0, 1'b1, NXT_STEP};
			STEP_W'(1):  w = '{OP_MAC, SRC_BPX1, PART_INT, C_BP_B2, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(2):  w = '{OP_MAC, SRC_BPX3, PART_INT, C_BP_B4, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(3):  w = '{OP_MAC, SRC_BPY0, PART_LO, C_BP_A1, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(4):  w = '{OP_MAC, SRC_BPY0, PART_HI, C_BP_A1, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(5):  w = '{OP_MAC, SRC_BPY1, PART_LO, C_BP_A2, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(6):  w = '{OP_MAC, SRC_BPY1, PART_HI, C_BP_A2, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(7):  w = '{OP_MAC, SRC_BPY2, PART_LO, C_BP_A3, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(8):  w = '{OP_MAC, SRC_BPY2, PART_HI, C_BP_A3, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(9):  w = '{OP_MAC, SRC_BPY3, PART_LO, C_BP_A4, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(10): w = '{OP_MAC, SRC_BPY3, PART_HI, C_BP_A4, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(11): w = '{OP_NOP, SRC_SAMPLE, PART_INT, C_BP_B0, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(12): w = '{OP_BP_END, SRC_SAMPLE, PART_INT, C_BP_B0, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(13): w = '{OP_MAC, SRC_ENVX0, PART_INT, C_ENV_B1, 1'b0, 1'b1, NXT_STEP};
			STEP_W'(14): w = '{OP_MAC, SRC_ENVX1, PART_INT, C_ENV_B2, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(15): w = '{OP_MAC, SRC_ENVY0, PART_LO, C_ENV_A1, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(16): w = '{OP_MAC, SRC_ENVY0, PART_HI, C_ENV_A1, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(17): w = '{OP_MAC, SRC_ENVY1, PART_LO, C_ENV_A2, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(18): w = '{OP_MAC, SRC_ENVY1, PART_HI, C_ENV_A2, 1'b1, 1'b0, NXT_STEP};
			STEP_W'(19): w = '{OP_MAC, SRC_RECT, PART_INT, C_ENV_B0, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(20): w = '{OP_NOP, SRC_SAMPLE, PART_INT, C_BP_B0, 1'b0, 1'b0, NXT_STEP};
			STEP_W'(21): w = '{OP_ENV_END, SRC_SAMPLE, PART_INT, C_BP_B0, 1'b0, 1'b0,
				NXT_WAIT_OUT};
			default:     w = '{OP_NOP, SRC_SAMPLE, PART_INT, C_BP_B0, 1'b0, 1'b0,
				NXT_WAIT_OUT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/iir_bandpass_envelope_event_detector.sv
// Top level of the bandpass envelope event detector: microcoded multiply-accumulate datapath.
//
// Channel   Direction  Handshake                   Word
// sample    in         sample_valid / sample_ready accel_sample
// result    out        result_valid / result_ready bandpass_value, envelope_value, event_code
// config    in         APB (psel, penable, ...)    event_threshold at byte address 0
//
// Each sample runs a 22-step program, one step per cycle, through one shared signed
// 32 x 24 multiplier and its accumulator; no new sample is taken before the last step completes.
// The last step waits while the result register is still full, so a stalled result
// holds the block on that step; a new sample may be taken in the cycle it completes.
// Reset arms the detector and clears all filter histories at once.
`default_nettype none
module iir_bandpass_envelope_event_detector #(
	parameter int SAMPLE_WIDTH = iirbpd_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = iirbpd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  sample_valid,
	output logic                                       sample_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]        accel_sample,
	output logic                                       result_valid,
	input  wire logic                                  result_ready,
	output logic signed [iirbpd_pkg::OUT_W-1:0]        bandpass_value,
	output logic signed [iirbpd_pkg::OUT_W-1:0]        envelope_value,
	output logic [1:0]                                 event_code,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [iirbpd_pkg::APB_AW-1:0]         paddr,
	input  wire logic [iirbpd_pkg::APB_DW-1:0]         pwdata,
	output logic [iirbpd_pkg::APB_DW-1:0]              prdata,
	output logic                                       pready
);

	localparam int OUT_W  = iirbpd_pkg::OUT_W;
	localparam int HIST_W = iirbpd_pkg::HIST_W;
	localparam int THR_W  = iirbpd_pkg::THR_W;
	localparam int STEP_W = iirbpd_pkg::STEP_W;
	localparam int HI_W   = HIST_W - FRAC_BITS;
	localparam int OPW_A  = (SAMPLE_WIDTH > OUT_W) ? SAMPLE_WIDTH : OUT_W;
	localparam int OPW_B  = (HI_W > FRAC_BITS + 1) ? HI_W : FRAC_BITS + 1;
	localparam int OPW    = (OPW_A > OPW_B) ? OPW_A : OPW_B;
	localparam int PW     = iirbpd_pkg::COEF_W + OPW;
	localparam int ACC_W  = PW + 4;
	localparam int S_H    = iirbpd_pkg::ACC_FRAC - FRAC_BITS;
	localparam int S_O    = iirbpd_pkg::ACC_FRAC;

	localparam logic signed [ACC_W-1:0] HALF_H = ACC_W'(1) << (S_H - 1);
	localparam logic signed [ACC_W-1:0] HALF_O = ACC_W'(1) << (S_O - 1);
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	typedef struct packed {
		logic valid;
		logic first;
		logic sub;
		logic lo;
	} mac_ctl_t;

	iirbpd_pkg::ucode_t uc;

	logic                      busy_q;
	logic [STEP_W-1:0]         step_q;
	logic [THR_W-1:0]          thr_q;
	logic                      in_motion_q;
	logic                      result_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] bp_x_q [4];
	logic signed [HIST_W-1:0]       bp_y_q [4];
	logic signed [OUT_W-1:0]        env_x_q [2];
	logic signed [HIST_W-1:0]       env_y_q [2];
	logic signed [OUT_W-1:0]        bp_q;
	logic signed [OUT_W-1:0]        rect_q;

	mac_ctl_t                  ctl_s1;
	logic signed [PW-1:0]      prod_s1;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [OUT_W-1:0]   bp_out_q;
	logic signed [OUT_W-1:0]   env_out_q;
	logic [1:0]                code_q;

	logic                      out_free;
	logic                      finish;
	logic                      accept;
	logic                      env_fire;
	logic                      cfg_write;

	logic signed [SAMPLE_WIDTH-1:0] int_in;
	logic signed [OUT_W-1:0]        int_out;
	logic                           int_is_out;
	logic signed [HIST_W-1:0]       y_sel;
	logic signed [OPW-1:0]          opnd;
	logic signed [iirbpd_pkg::COEF_W-1:0] coef;

	logic signed [PW-1:0]      term;
	logic signed [ACC_W-1:0]   term_ext;

	logic signed [ACC_W-1:0]   hist_sum;
	logic signed [ACC_W-1:0]   hist_full;
	logic signed [ACC_W-1:0]   out_sum;
	logic signed [ACC_W-1:0]   out_full;
	logic [ACC_W-HIST_W:0]     hist_top;
	logic [ACC_W-OUT_W:0]      out_top;
	logic signed [HIST_W-1:0]  y_new;
	logic signed [OUT_W-1:0]   o_new;
	logic signed [OUT_W-1:0]   rect_next;
	logic signed [OUT_W-1:0]   thr_s;
	logic [1:0]                code_next;
	logic                      motion_next;

	assign uc = iirbpd_pkg::ucode_rom(step_q);

	assign out_free     = !result_valid_q || result_ready;
	assign finish       = busy_q && (uc.nxt == iirbpd_pkg::NXT_WAIT_OUT) && out_free;
	assign sample_ready = !busy_q || finish;
	assign accept       = sample_valid && sample_ready;
	assign env_fire     = finish && (uc.op == iirbpd_pkg::OP_ENV_END);

	assign cfg_write = psel && penable && pwrite && (paddr[2] == iirbpd_pkg::REG_THRESHOLD);
	assign pready    = 1'b1;
	assign prdata    = (psel && (paddr[2] == iirbpd_pkg::REG_THRESHOLD)) ?
		iirbpd_pkg::APB_DW'(thr_q) : '0;

	assign result_valid   = result_valid_q;
	assign bandpass_value = bp_out_q;
	assign envelope_value = env_out_q;
	assign event_code     = code_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		int_in     = sample_q;
		int_out    = rect_q;
		int_is_out = 1'b0;
		y_sel      = bp_y_q[0];
		case (uc.src)
			iirbpd_pkg::SRC_SAMPLE: int_in = sample_q;
			iirbpd_pkg::SRC_BPX1:   int_in = bp_x_q[1];
			iirbpd_pkg::SRC_BPX3:   int_in = bp_x_q[3];
			iirbpd_pkg::SRC_BPY0:   y_sel = bp_y_q[0];
			iirbpd_pkg::SRC_BPY1:   y_sel = bp_y_q[1];
			iirbpd_pkg::SRC_BPY2:   y_sel = bp_y_q[2];
			iirbpd_pkg::SRC_BPY3:   y_sel = bp_y_q[3];
			iirbpd_pkg::SRC_RECT: begin
				int_out    = rect_q;
				int_is_out = 1'b1;
			end
			iirbpd_pkg::SRC_ENVX0: begin
				int_out    = env_x_q[0];
				int_is_out = 1'b1;
			end
			iirbpd_pkg::SRC_ENVX1: begin
				int_out    = env_x_q[1];
				int_is_out = 1'b1;
			end
			iirbpd_pkg::SRC_ENVY0:  y_sel = env_y_q[0];
			iirbpd_pkg::SRC_ENVY1:  y_sel = env_y_q[1];
			default:                int_in = sample_q;
		endcase
		case (uc.part)
			iirbpd_pkg::PART_LO: opnd = OPW'({1'b0, y_sel[FRAC_BITS-1:0]});
			iirbpd_pkg::PART_HI: opnd = OPW'($signed(y_sel[HIST_W-1:FRAC_BITS]));
			iirbpd_pkg::PART_INT: opnd = int_is_out ? OPW'(int_out) : OPW'(int_in);
			default:             opnd = '0;
		endcase
		coef = iirbpd_pkg::coef_rom(uc.coef);
	end

	// The low-part product of a feedback term is floored down by the fraction bits.
	always_comb begin
		term     = ctl_s1.lo ? (prod_s1 >>> FRAC_BITS) : prod_s1;
		term_ext = ACC_W'(term);
	end

	// Rounding half away from zero, then saturation, for history and integer output.
	always_comb begin
		hist_sum  = acc_q + HALF_H - ACC_W'(acc_q[ACC_W-1]);
		hist_full = hist_sum >>> S_H;
		hist_top  = hist_full[ACC_W-1:HIST_W-1];
		if ((&hist_top) || !(|hist_top)) begin
			y_new = hist_full[HIST_W-1:0];
		end else begin
			y_new = {hist_full[ACC_W-1], {(HIST_W-1){~hist_full[ACC_W-1]}}};
		end
		out_sum  = acc_q + HALF_O - ACC_W'(acc_q[ACC_W-1]);
		out_full = out_sum >>> S_O;
		out_top  = out_full[ACC_W-1:OUT_W-1];
		if ((&out_top) || !(|out_top)) begin
			o_new = out_full[OUT_W-1:0];
		end else begin
			o_new = {out_full[ACC_W-1], {(OUT_W-1){~out_full[ACC_W-1]}}};
		end
	end

	// Rectifier and threshold detector.
	always_comb begin
		if (!bp_q[OUT_W-1]) begin
			rect_next = bp_q;
		end else if (bp_q == OUT_MIN) begin
			rect_next = OUT_MAX;
		end else begin
			rect_next = -bp_q;
		end
		thr_s       = $signed({1'b0, thr_q});
		code_next   = iirbpd_pkg::EVT_NONE;
		motion_next = in_motion_q;
		if (!in_motion_q && (o_new > thr_s)) begin
			code_next   = iirbpd_pkg::EVT_START;
			motion_next = 1'b1;
		end else if (in_motion_q && (o_new < thr_s)) begin
			code_next   = iirbpd_pkg::EVT_STOP;
			motion_next = 1'b0;
		end
	end

	// Sequencer, configuration and detector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			step_q         <= '0;
			thr_q          <= iirbpd_pkg::THR_RESET;
			in_motion_q    <= 1'b0;
			result_valid_q <= 1'b0;
			ctl_s1         <= '0;
		end else begin
			if (cfg_write) begin
				thr_q <= pwdata[THR_W-1:0];
			end
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else if (busy_q && (uc.nxt == iirbpd_pkg::NXT_STEP)) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (env_fire) begin
				in_motion_q    <= motion_next;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			ctl_s1.valid <= busy_q && (uc.op == iirbpd_pkg::OP_MAC);
			ctl_s1.first <= uc.first;
			ctl_s1.sub   <= uc.sub;
			ctl_s1.lo    <= (uc.part == iirbpd_pkg::PART_LO);
		end
	end

	// Filter histories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_x_q  <= '{default: '0};
			bp_y_q  <= '{default: '0};
			env_x_q <= '{default: '0};
			env_y_q <= '{default: '0};
		end else begin
			if (busy_q && (uc.op == iirbpd_pkg::OP_BP_END)) begin
				bp_x_q <= '{sample_q, bp_x_q[0], bp_x_q[1], bp_x_q[2]};
				bp_y_q <= '{y_new, bp_y_q[0], bp_y_q[1], bp_y_q[2]};
			end
			if (env_fire) begin
				env_x_q <= '{rect_q, env_x_q[0]};
				env_y_q <= '{y_new, env_y_q[0]};
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= accel_sample;
		end
		prod_s1 <= coef * opnd;
		if (ctl_s1.valid) begin
			if (ctl_s1.first) begin
				acc_q <= ctl_s1.sub ? -term_ext : term_ext;
			end else begin
				acc_q <= ctl_s1.sub ? (acc_q - term_ext) : (acc_q + term_ext);
			end
		end
		if (busy_q && (uc.op == iirbpd_pkg::OP_BP_END)) begin
			bp_q <= o_new;
		end
		rect_q <= rect_next;
		if (env_fire) begin
			bp_out_q  <= bp_q;
			env_out_q <= o_new;
			code_q    <= code_next;
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= iirbpd_pkg::LAST_STEP)
		else $error("step counter ran past the end of the program");

	a_motion_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!env_fire |=> $stable(in_motion_q))
		else $error("motion state changed without a result");

	a_code_matches_motion: assert property (@(posedge clk) disable iff (!arst_n)
		env_fire |=> ((event_code == iirbpd_pkg::EVT_NONE) == $stable(in_motion_q)))
		else $error("event code disagrees with the motion state");

	a_bp_hist_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && (uc.op == iirbpd_pkg::OP_BP_END)) |=> $stable(bp_y_q[0]))
		else $error("bandpass history moved outside its update step");

endmodule
`default_nettype wire
